>>> src/normalized_chirp_correlator_assert.svh
// Assertion macros for the correlator checker
`ifndef NORMALIZED_CHIRP_CORRELATOR_ASSERT_SVH
`define NORMALIZED_CHIRP_CORRELATOR_ASSERT_SVH

// same-cycle implication
`define NCC_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define NCC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/ncc_pkg.sv
package ncc_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int OPCODE_W   = 2;
   localparam int INDEX_W    = 9;
   localparam int SCORE_W    = 48;
   localparam int SEEN_W     = 32;
   localparam int FLOOR_W    = 39;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 39;
   localparam int PROD_W     = 2 * SAMPLE_W;
   localparam int SQ_W       = 2 * SAMPLE_W - 1;
   localparam int FRAC2      = 2 * (SAMPLE_W - 1);
   localparam int Q_W        = SAMPLE_W;
   localparam int Q_MAX      = (1 << (SAMPLE_W - 1)) - 1;

   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [SCORE_W-1:0]  score_type;

   localparam score_type SCORE_MIN = {1'b1, {(SCORE_W - 1){1'b0}}};

   typedef enum logic [OPCODE_W-1:0] {
      OP_SAMPLE = 2'd0,
      OP_LOAD   = 2'd1,
      OP_CLEAR  = 2'd2
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SCORE_MODE   = 1'b0,
      CSR_ENERGY_FLOOR = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic clear;
      logic valid;
   } mac_ctl_type;

endpackage

>>> src/ncc_mac.sv
module ncc_mac #(
   parameter int ENERGY_W = 40
) (
   input  logic                       clock,
   input  logic                       reset,
   input  ncc_pkg::mac_ctl_type       ctl,
   input  ncc_pkg::sample_type        sample,
   input  ncc_pkg::sample_type        coef,
   output logic signed [ENERGY_W:0]   dot,
   output logic [ENERGY_W-1:0]        energy
);

   localparam int DW = ENERGY_W + 1;

   logic                                 v_ff;
   logic signed [ncc_pkg::PROD_W-1:0]    prod_ff, prod_in;
   logic signed [ncc_pkg::PROD_W-1:0]    sq_full;
   logic [ncc_pkg::SQ_W-1:0]             sq_ff;
   logic signed [DW-1:0]                 dot_ff;
   logic [ENERGY_W-1:0]                  energy_ff;

   always_comb begin
      prod_in = sample * coef;
      sq_full = sample * sample;
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      sq_ff   <= sq_full[ncc_pkg::SQ_W-1:0];
      if (ctl.clear) begin
         dot_ff    <= '0;
         energy_ff <= '0;
      end else if (v_ff) begin
         dot_ff    <= dot_ff + DW'(prod_ff);
         energy_ff <= energy_ff + ENERGY_W'(sq_ff);
      end
      if (reset) begin
         v_ff <= 1'b0;
      end else begin
         v_ff <= ctl.valid;
      end
   end

   assign dot    = dot_ff;
   assign energy = energy_ff;

endmodule

>>> src/ncc_norm.sv
module ncc_norm #(
   parameter int ENERGY_W = 40
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic signed [ENERGY_W:0]  dot,
   input  logic [ENERGY_W-1:0]       es,
   input  logic [ENERGY_W-1:0]       et,
   output logic                      done,
   output ncc_pkg::score_type        score
);

   localparam int DW   = ENERGY_W + 1;
   localparam int HW   = (ENERGY_W + 1) / 2;
   localparam int PW   = 2 * ENERGY_W;
   localparam int RW   = PW + ncc_pkg::FRAC2;
   localparam int BW   = RW + 1;
   localparam int CW   = RW + 2;
   localparam int QW   = ncc_pkg::Q_W;
   localparam int BITW = $clog2(ncc_pkg::Q_W);
   localparam logic [2:0] PP_LAST = 3'd7;

   typedef enum logic [2:0] {
      N_IDLE, N_MUL, N_WAIT, N_INIT, N_ADD, N_CMP, N_DONE
   } state_type;

   state_type              state_ff, state_in;
   logic                   mul_v_ff, mul_v_in;
   logic [2:0]             i_ff, i_in;
   logic [2:0]             pi_ff, pi_in;
   logic [2*HW-1:0]        prod_ff, prod_in;
   logic [ENERGY_W-1:0]    es_ff, es_in, et_ff, et_in, mag_ff, mag_in;
   logic                   neg_ff, neg_in;
   logic [PW-1:0]          p_ff, p_in, m_ff, m_in;
   logic [RW-1:0]          a_ff, a_in, s_ff, s_in;
   logic [BW-1:0]          b_ff, b_in;
   logic [CW-1:0]          c_ff, c_in;
   logic [QW-1:0]          q_ff, q_in;
   logic [BITW-1:0]        bit_ff, bit_in;

   logic signed [DW-1:0]   dot_neg;
   logic [2*HW-1:0]        xw, yw;
   logic [HW-1:0]          xh, yh;
   logic [PW-1:0]          term;
   logic [RW-1:0]          r_val;
   logic signed [QW:0]     q_ext;

   always_comb begin
      state_in = state_ff;
      mul_v_in = 1'b0;
      i_in     = i_ff;
      pi_in    = i_ff;
      es_in    = es_ff;
      et_in    = et_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      p_in     = p_ff;
      m_in     = m_ff;
      a_in     = a_ff;
      b_in     = b_ff;
      s_in     = s_ff;
      c_in     = c_ff;
      q_in     = q_ff;
      bit_in   = bit_ff;

      dot_neg = -dot;
      xw = i_ff[2] ? (2*HW)'(mag_ff) : (2*HW)'(es_ff);
      yw = i_ff[2] ? (2*HW)'(mag_ff) : (2*HW)'(et_ff);
      xh = i_ff[0] ? xw[2*HW-1:HW] : xw[HW-1:0];
      yh = i_ff[1] ? yw[2*HW-1:HW] : yw[HW-1:0];
      prod_in = xh * yh;

      if (pi_ff[0] & pi_ff[1]) begin
         term = PW'(prod_ff) << (2 * HW);
      end else if (pi_ff[0] ^ pi_ff[1]) begin
         term = PW'(prod_ff) << HW;
      end else begin
         term = PW'(prod_ff);
      end
      if (mul_v_ff) begin
         if (pi_ff[2]) begin
            m_in = m_ff + term;
         end else begin
            p_in = p_ff + term;
         end
      end

      r_val = {m_ff, {ncc_pkg::FRAC2{1'b0}}};

      case (state_ff)
         N_IDLE: begin
            if (start) begin
               es_in  = es;
               et_in  = et;
               neg_in = dot[DW-1];
               mag_in = dot[DW-1] ? dot_neg[ENERGY_W-1:0] : dot[ENERGY_W-1:0];
               i_in   = '0;
               p_in   = '0;
               m_in   = '0;
               state_in = N_MUL;
            end
         end
         N_MUL: begin
            mul_v_in = 1'b1;
            i_in = i_ff + 3'd1;
            if (i_ff == PP_LAST) begin
               state_in = N_WAIT;
            end
         end
         N_WAIT: begin
            state_in = N_INIT;
         end
         N_INIT: begin
            a_in   = RW'(p_ff) << ncc_pkg::FRAC2;
            b_in   = '0;
            s_in   = '0;
            q_in   = '0;
            bit_in = BITW'(QW - 1);
            state_in = N_ADD;
         end
         N_ADD: begin
            c_in = CW'(s_ff) + CW'(a_ff) + CW'(b_ff);
            state_in = N_CMP;
         end
         N_CMP: begin
            // keep this bit while (q + 2^bit)^2 * P stays within R
            if (c_ff <= CW'(r_val)) begin
               s_in = c_ff[RW-1:0];
               q_in[bit_ff] = 1'b1;
               b_in = (b_ff >> 1) + BW'(a_ff);
            end else begin
               b_in = b_ff >> 1;
            end
            a_in = a_ff >> 2;
            if (bit_ff == '0) begin
               state_in = N_DONE;
            end else begin
               bit_in = bit_ff - 1'b1;
               state_in = N_ADD;
            end
         end
         N_DONE: begin
            state_in = N_IDLE;
         end
         default: begin
            state_in = N_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      i_ff    <= i_in;
      pi_ff   <= pi_in;
      prod_ff <= prod_in;
      es_ff   <= es_in;
      et_ff   <= et_in;
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      p_ff    <= p_in;
      m_ff    <= m_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      s_ff    <= s_in;
      c_ff    <= c_in;
      q_ff    <= q_in;
      bit_ff  <= bit_in;
      if (reset) begin
         state_ff <= N_IDLE;
         mul_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mul_v_ff <= mul_v_in;
      end
   end

   always_comb begin
      q_ext = $signed({1'b0, q_ff});
      if (neg_ff) begin
         score = ncc_pkg::score_type'(-q_ext);
      end else if (q_ff[QW-1]) begin
         score = ncc_pkg::score_type'(ncc_pkg::Q_MAX);
      end else begin
         score = ncc_pkg::score_type'(q_ext);
      end
   end

   assign done = (state_ff == N_DONE);

endmodule

>>> src/normalized_chirp_correlator.sv
// Sliding-window matched filter for a preamble chirp. After reset the template store is
// swept to zero with req_ready low; CSR writes are taken at any
// time. A template load passes through ST_LOAD_SQ and ST_LOAD_UPD, then back to idle;
// a clear or a sample that does not yet fill the window is taken in ST_IDLE. A sample with a
// full window runs one shared MAC (product and square per cycle) over the window and
// drains it; in normalized mode, unless an energy is zero or under the floor (score 0),
// one iterative unit then forms Es*Et and D^2 in 8 half-width multiplies and finds the
// quotient of dot/sqrt(Es*Et) one bit at a time. Samples are taken one at a time. The result word
// sits in an output register, so a stalled consumer only holds off the next result.
module normalized_chirp_correlator #(
   parameter int TEMPLATE_LEN = 440
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [ncc_pkg::OPCODE_W-1:0]        req_opcode,
   input  logic signed [ncc_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic [ncc_pkg::INDEX_W-1:0]         req_coef_index,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [ncc_pkg::SCORE_W-1:0]  rsp_score,
   output logic [ncc_pkg::SEEN_W-1:0]          rsp_window_start,
   output logic signed [ncc_pkg::SCORE_W-1:0]  rsp_best_score,
   output logic [ncc_pkg::SEEN_W-1:0]          rsp_best_index,
   output logic                                rsp_new_best,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [ncc_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [ncc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int IW  = $clog2(TEMPLATE_LEN);
   localparam int EW  = ncc_pkg::SQ_W + $clog2(TEMPLATE_LEN);
   localparam int DW  = EW + 1;
   localparam int EXW = (EW > ncc_pkg::FLOOR_W) ? EW : ncc_pkg::FLOOR_W;
   localparam int SW  = ncc_pkg::SEEN_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(TEMPLATE_LEN - 1);
   localparam logic [1:0] DRAIN_LAST = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_LOAD_SQ, ST_LOAD_UPD, ST_MAC, ST_DRAIN, ST_NORM, ST_OUT
   } state_type;

   state_type                    state_ff, state_in;
   logic [IW-1:0]                j_ff, j_in, k_ff, k_in, ptr_ff, ptr_in;
   logic [IW-1:0]                load_idx_ff, load_idx_in;
   ncc_pkg::sample_type          load_val_ff, load_val_in;
   logic [ncc_pkg::SQ_W-1:0]     new_sq_ff, new_sq_in, old_sq_ff, old_sq_in;
   logic [EW-1:0]                energy_ff, energy_in;
   logic [SW-1:0]                seen_ff, seen_in, ws_ff, ws_in;
   ncc_pkg::score_type           best_score_ff, best_score_in, score_ff, score_in;
   logic [SW-1:0]                best_index_ff, best_index_in;
   logic                         mode_ff, mode_in;
   logic [ncc_pkg::FLOOR_W-1:0]  floor_ff, floor_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic [1:0]                   drain_ff, drain_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   ncc_pkg::score_type           rsp_score_ff, rsp_score_in;
   ncc_pkg::score_type           rsp_best_score_ff, rsp_best_score_in;
   logic [SW-1:0]                rsp_ws_ff, rsp_ws_in, rsp_best_index_ff, rsp_best_index_in;
   logic                         rsp_new_best_ff, rsp_new_best_in;

   ncc_pkg::sample_type          tpl_mem [TEMPLATE_LEN];
   ncc_pkg::sample_type          win_mem [TEMPLATE_LEN];
   ncc_pkg::sample_type          tpl_rd_ff, win_rd_ff, tpl_wdata;
   logic [IW-1:0]                tpl_raddr, tpl_waddr;
   logic                         tpl_we, win_we;

   ncc_pkg::mac_ctl_type         mac_ctl;
   logic signed [DW-1:0]         mac_dot;
   logic [EW-1:0]                mac_es;
   logic                         norm_start, norm_done;
   ncc_pkg::score_type           norm_score;

   logic                         req_fire;
   logic [SW-1:0]                seen_next;
   logic [IW-1:0]                ptr_next;
   logic signed [ncc_pkg::PROD_W-1:0] new_prod, old_prod;
   logic                         low_energy, nb;

   ncc_mac #(.ENERGY_W(EW)) u_ncc_mac (
      .clock  (clock),
      .reset  (reset),
      .ctl    (mac_ctl),
      .sample (win_rd_ff),
      .coef   (tpl_rd_ff),
      .dot    (mac_dot),
      .energy (mac_es)
   );

   ncc_norm #(.ENERGY_W(EW)) u_ncc_norm (
      .clock (clock),
      .reset (reset),
      .start (norm_start),
      .dot   (mac_dot),
      .es    (mac_es),
      .et    (energy_ff),
      .done  (norm_done),
      .score (norm_score)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in          = state_ff;
      j_in              = j_ff;
      k_in              = k_ff;
      ptr_in            = ptr_ff;
      load_idx_in       = load_idx_ff;
      load_val_in       = load_val_ff;
      new_sq_in         = new_sq_ff;
      old_sq_in         = old_sq_ff;
      energy_in         = energy_ff;
      seen_in           = seen_ff;
      ws_in             = ws_ff;
      best_score_in     = best_score_ff;
      best_index_in     = best_index_ff;
      score_in          = score_ff;
      mode_in           = mode_ff;
      floor_in          = floor_ff;
      rd_valid_in       = 1'b0;
      drain_in          = drain_ff;
      rsp_valid_in      = rsp_valid_ff & ~rsp_ready;
      rsp_score_in      = rsp_score_ff;
      rsp_ws_in         = rsp_ws_ff;
      rsp_best_score_in = rsp_best_score_ff;
      rsp_best_index_in = rsp_best_index_ff;
      rsp_new_best_in   = rsp_new_best_ff;

      tpl_we     = 1'b0;
      tpl_waddr  = load_idx_ff;
      tpl_wdata  = load_val_ff;
      tpl_raddr  = j_ff;
      win_we     = 1'b0;
      mac_ctl    = '0;
      mac_ctl.valid = rd_valid_ff;
      norm_start = 1'b0;

      seen_next = (seen_ff == '1) ? seen_ff : seen_ff + 1'b1;
      ptr_next  = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
      new_prod  = req_sample_value * req_sample_value;
      old_prod  = tpl_rd_ff * tpl_rd_ff;
      low_energy = (EXW'(mac_es) < EXW'(floor_ff)) || (EXW'(energy_ff) < EXW'(floor_ff))
                   || (mac_es == '0) || (energy_ff == '0);
      nb = (score_ff > best_score_ff);

      if (csr_valid) begin
         case (ncc_pkg::csr_index_type'(csr_index))
            ncc_pkg::CSR_SCORE_MODE:   mode_in  = csr_wdata[0];
            ncc_pkg::CSR_ENERGY_FLOOR: floor_in = csr_wdata[ncc_pkg::FLOOR_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_CLEAR: begin
            tpl_we    = 1'b1;
            tpl_waddr = j_ff;
            tpl_wdata = '0;
            if (j_ff == LAST_IDX) begin
               j_in = '0;
               state_in = ST_IDLE;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            tpl_raddr = IW'(req_coef_index);
            if (req_fire) begin
               case (ncc_pkg::opcode_type'(req_opcode))
                  ncc_pkg::OP_SAMPLE: begin
                     win_we  = 1'b1;
                     ptr_in  = ptr_next;
                     seen_in = seen_next;
                     if (seen_next >= SW'(TEMPLATE_LEN)) begin
                        ws_in = seen_next - SW'(TEMPLATE_LEN);
                        k_in  = ptr_next;
                        j_in  = '0;
                        mac_ctl.clear = 1'b1;
                        state_in = ST_MAC;
                     end
                  end
                  ncc_pkg::OP_LOAD: begin
                     if (32'(req_coef_index) < 32'(TEMPLATE_LEN)) begin
                        load_idx_in = IW'(req_coef_index);
                        load_val_in = req_sample_value;
                        new_sq_in   = new_prod[ncc_pkg::SQ_W-1:0];
                        state_in    = ST_LOAD_SQ;
                     end
                  end
                  ncc_pkg::OP_CLEAR: begin
                     best_score_in = ncc_pkg::SCORE_MIN;
                     best_index_in = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_LOAD_SQ: begin
            old_sq_in = old_prod[ncc_pkg::SQ_W-1:0];
            state_in  = ST_LOAD_UPD;
         end
         ST_LOAD_UPD: begin
            energy_in = energy_ff + EW'(new_sq_ff) - EW'(old_sq_ff);
            tpl_we    = 1'b1;
            state_in  = ST_IDLE;
         end
         ST_MAC: begin
            // oldest sample pairs with template position 0
            rd_valid_in = 1'b1;
            k_in = (k_ff == LAST_IDX) ? '0 : k_ff + 1'b1;
            if (j_ff == LAST_IDX) begin
               j_in     = '0;
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               if (!mode_ff) begin
                  score_in = ncc_pkg::score_type'(mac_dot);
                  state_in = ST_OUT;
               end else if (low_energy) begin
                  score_in = '0;
                  state_in = ST_OUT;
               end else begin
                  norm_start = 1'b1;
                  state_in   = ST_NORM;
               end
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         ST_NORM: begin
            if (norm_done) begin
               score_in = norm_score;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in      = 1'b1;
               rsp_score_in      = score_ff;
               rsp_ws_in         = ws_ff;
               rsp_new_best_in   = nb;
               rsp_best_score_in = nb ? score_ff : best_score_ff;
               rsp_best_index_in = nb ? ws_ff : best_index_ff;
               if (nb) begin
                  best_score_in = score_ff;
                  best_index_in = ws_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      k_ff              <= k_in;
      load_idx_ff       <= load_idx_in;
      load_val_ff       <= load_val_in;
      new_sq_ff         <= new_sq_in;
      old_sq_ff         <= old_sq_in;
      ws_ff             <= ws_in;
      score_ff          <= score_in;
      rsp_score_ff      <= rsp_score_in;
      rsp_ws_ff         <= rsp_ws_in;
      rsp_best_score_ff <= rsp_best_score_in;
      rsp_best_index_ff <= rsp_best_index_in;
      rsp_new_best_ff   <= rsp_new_best_in;
      if (reset) begin
         state_ff      <= ST_CLEAR;
         j_ff          <= '0;
         ptr_ff        <= '0;
         energy_ff     <= '0;
         seen_ff       <= '0;
         best_score_ff <= ncc_pkg::SCORE_MIN;
         best_index_ff <= '0;
         mode_ff       <= 1'b1;
         floor_ff      <= ncc_pkg::FLOOR_W'(1);
         rd_valid_ff   <= 1'b0;
         drain_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         j_ff          <= j_in;
         ptr_ff        <= ptr_in;
         energy_ff     <= energy_in;
         seen_ff       <= seen_in;
         best_score_ff <= best_score_in;
         best_index_ff <= best_index_in;
         mode_ff       <= mode_in;
         floor_ff      <= floor_in;
         rd_valid_ff   <= rd_valid_in;
         drain_ff      <= drain_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tpl_we) begin
         tpl_mem[tpl_waddr] <= tpl_wdata;
      end
      tpl_rd_ff <= tpl_mem[tpl_raddr];
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         win_mem[ptr_ff] <= req_sample_value;
      end
      win_rd_ff <= win_mem[k_ff];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_score        = rsp_score_ff;
   assign rsp_window_start = rsp_ws_ff;
   assign rsp_best_score   = rsp_best_score_ff;
   assign rsp_best_index   = rsp_best_index_ff;
   assign rsp_new_best     = rsp_new_best_ff;

endmodule

>>> src/ncc_checker.sv
`include "normalized_chirp_correlator_assert.svh"

module ncc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [ncc_pkg::SCORE_W-1:0]  rsp_score,
   input logic [ncc_pkg::SEEN_W-1:0]          rsp_window_start,
   input logic signed [ncc_pkg::SCORE_W-1:0]  rsp_best_score,
   input logic [ncc_pkg::SEEN_W-1:0]          rsp_best_index,
   input logic                                rsp_new_best
);

   `NCC_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_score) && $stable(rsp_best_score), "result word changed while stalled")

   `NCC_ASSERT_IMPLY(a_best_follows, rsp_valid && rsp_new_best, rsp_best_score == rsp_score && rsp_best_index == rsp_window_start, "new best does not match its score")

   `NCC_ASSERT_IMPLY(a_best_bound, rsp_valid, rsp_best_score >= rsp_score, "best score below current score")

   `NCC_ASSERT_IMPLY(a_busy_result, $rose(rsp_valid), $past(!req_ready), "result appeared while input side was open")

   `NCC_ASSERT_IMPLY(a_clear_pass, $past(reset), !req_ready && !rsp_valid, "block open right after reset")

endmodule

bind normalized_chirp_correlator ncc_checker u_ncc_checker (.*);
